FILE: src/pft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_pkg: shared types and constants of the PPP frame transmitter
// Word types of both channels, the queue entry between front and back, the
// framing constants and the ones' complement adder.
// ----------------------------------------------------------------------------
package pft_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [7:0]  ADDR_BYTE = 8'hFF;
	localparam logic [7:0]  CTRL_BYTE = 8'h03;
	localparam logic [15:0] HDR_WORD  = {ADDR_BYTE, CTRL_BYTE};

	// queue between front and back
	localparam int QPTR_W = 2;
	localparam int QDEPTH = 1 << QPTR_W;
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
	} out_word_t;

	// one classified payload byte, everything the back needs to frame it
	typedef struct packed {
		logic        hdr;
		logic [15:0] proto;
		logic        esc;
		logic [7:0]  data;
		logic        last;
		logic [15:0] csum;
	} entry_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

	// 16-bit ones' complement add with end-around carry
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

FILE: src/pft_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_front: input side of the PPP frame transmitter
// Accepts payload words, tracks frame state and the running checksum, and
// pushes one classified entry per word into the queue.
// ----------------------------------------------------------------------------
module pft_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                item_valid,
	output logic                item_ready,
	input  pft_pkg::in_word_t   item,
	input  pft_pkg::q_status_t  q_status,
	output logic                push,
	output pft_pkg::entry_t     push_entry
);

	logic        in_frame_q;
	logic        have_pend_q;
	logic [7:0]  pend_q;
	logic [15:0] sum_q;
	logic [15:0] proto_q;
	logic [15:0] hdr_sum_q;

	logic [15:0] base;
	logic [15:0] addend;
	logic        do_add;
	logic [15:0] sum_n;

	assign item_ready = !q_status.full;
	assign push       = item_valid && item_ready;

	// header part of the sum is folded at config time, so at most one add per word
	assign base   = in_frame_q ? sum_q : hdr_sum_q;
	assign addend = have_pend_q ? {pend_q, item.data_byte} : {item.data_byte, 8'h00};
	assign do_add = have_pend_q || item.last_byte;
	assign sum_n  = do_add ? pft_pkg::ones_add(base, addend) : base;

	always_comb begin
		push_entry.hdr   = !in_frame_q;
		push_entry.proto = proto_q;
		push_entry.esc   = (item.data_byte == pft_pkg::ESC_BYTE) ||
		                   (item.data_byte == pft_pkg::FLAG_BYTE);
		push_entry.data  = item.data_byte;
		push_entry.last  = item.last_byte;
		push_entry.csum  = ~sum_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_q   <= 16'd0;
			hdr_sum_q <= pft_pkg::HDR_WORD;
		end else if (cfg_we) begin
			proto_q   <= cfg_wdata;
			hdr_sum_q <= pft_pkg::ones_add(pft_pkg::HDR_WORD, cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			have_pend_q <= 1'b0;
			sum_q       <= 16'd0;
		end else if (push) begin
			if (item.last_byte) begin
				in_frame_q  <= 1'b0;
				have_pend_q <= 1'b0;
				sum_q       <= 16'd0;
			end else begin
				in_frame_q  <= 1'b1;
				have_pend_q <= !have_pend_q;
				sum_q       <= sum_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_q <= item.data_byte;
		end
	end

endmodule

FILE: src/pft_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_queue: entry queue between front and back
// Small register FIFO; the head entry is visible without a pop.
// ----------------------------------------------------------------------------
module pft_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pft_pkg::entry_t     push_entry,
	input  logic                pop,
	output pft_pkg::entry_t     head,
	output pft_pkg::q_status_t  q_status
);

	pft_pkg::entry_t               mem_q [pft_pkg::QDEPTH];
	logic [pft_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [pft_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [pft_pkg::QCNT_W-1:0]    count_q;

	assign head               = mem_q[rd_ptr_q];
	assign q_status.not_empty = (count_q != '0);
	assign q_status.full      = (count_q == pft_pkg::QCNT_W'(pft_pkg::QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

FILE: src/pft_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_back: output sequencer of the PPP frame transmitter
// Walks the head entry byte by byte (header, stuffed data, trailer) into the
// output register, one byte per cycle unless stalled, and pops it when done.
// ----------------------------------------------------------------------------
module pft_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pft_pkg::entry_t     head,
	input  pft_pkg::q_status_t  q_status,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_ready,
	output pft_pkg::out_word_t  result
);

	typedef enum logic [10:0] {
		ST_FIRST = 11'b000_0000_0001,
		ST_FLAG0 = 11'b000_0000_0010,
		ST_ADDR  = 11'b000_0000_0100,
		ST_CTRL  = 11'b000_0000_1000,
		ST_PHI   = 11'b000_0001_0000,
		ST_PLO   = 11'b000_0010_0000,
		ST_BYTE  = 11'b000_0100_0000,
		ST_XOR   = 11'b000_1000_0000,
		ST_CSHI  = 11'b001_0000_0000,
		ST_CSLO  = 11'b010_0000_0000,
		ST_FLAG1 = 11'b100_0000_0000
	} phase_t;

	phase_t state_q;
	phase_t phase;
	phase_t next_phase;
	logic   done;
	logic   take;
	logic   out_valid_q;
	pft_pkg::out_word_t out_q;
	pft_pkg::out_word_t word;

	assign take = q_status.not_empty && (!out_valid_q || result_ready);
	assign pop  = take && done;

	// at the start of an entry the header flag decides where to begin
	always_comb begin
		if (state_q == ST_FIRST) begin
			phase = head.hdr ? ST_FLAG0 : ST_BYTE;
		end else begin
			phase = state_q;
		end
	end

	always_comb begin
		word.frame_end = 1'b0;
		word.out_byte  = head.data;
		next_phase     = ST_FIRST;
		done           = 1'b0;
		unique case (phase)
			ST_FLAG0: begin
				word.out_byte = pft_pkg::FLAG_BYTE;
				next_phase    = ST_ADDR;
			end
			ST_ADDR: begin
				word.out_byte = pft_pkg::ADDR_BYTE;
				next_phase    = ST_CTRL;
			end
			ST_CTRL: begin
				word.out_byte = pft_pkg::CTRL_BYTE;
				next_phase    = ST_PHI;
			end
			ST_PHI: begin
				word.out_byte = head.proto[15:8];
				next_phase    = ST_PLO;
			end
			ST_PLO: begin
				word.out_byte = head.proto[7:0];
				next_phase    = ST_BYTE;
			end
			ST_BYTE: begin
				if (head.esc) begin
					word.out_byte = pft_pkg::ESC_BYTE;
					next_phase    = ST_XOR;
				end else begin
					word.out_byte = head.data;
					next_phase    = head.last ? ST_CSHI : ST_FIRST;
					done          = !head.last;
				end
			end
			ST_XOR: begin
				word.out_byte = head.data ^ pft_pkg::ESC_XOR;
				next_phase    = head.last ? ST_CSHI : ST_FIRST;
				done          = !head.last;
			end
			ST_CSHI: begin
				word.out_byte = head.csum[15:8];
				next_phase    = ST_CSLO;
			end
			ST_CSLO: begin
				word.out_byte = head.csum[7:0];
				next_phase    = ST_FLAG1;
			end
			ST_FLAG1: begin
				word.out_byte  = pft_pkg::FLAG_BYTE;
				word.frame_end = 1'b1;
				next_phase     = ST_FIRST;
				done           = 1'b1;
			end
			default: begin
				next_phase = ST_FIRST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				state_q     <= next_phase;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= word;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: src/ppp_frame_transmitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_frame_transmitter: PPP/HDLC byte-stuffing framer
// Frames payload words with flag, address, control and protocol header,
// escapes 7D/7E, and appends the ones' complement checksum and closing flag.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------
//  item     | item_valid / item_ready     | data_byte[7:0], last_byte
//  result   | result_valid / result_ready | out_byte[7:0], frame_end
//  config   | cfg_we                      | cfg_wdata[15:0] protocol_number
//
// Output runs at one byte per cycle when not stalled: a payload word gives
// one byte, two when escaped, plus five header bytes for a first word and
// three trailer bytes for a last word. The rate is set by the back
// sequencer's single byte slot. A 4-entry queue absorbs output stalls
// before item_ready drops. Reset closes any open frame and sets the
// protocol register to 0.
// ----------------------------------------------------------------------------
module ppp_frame_transmitter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                item_valid,
	output logic                item_ready,
	input  pft_pkg::in_word_t   item,
	output logic                result_valid,
	input  logic                result_ready,
	output pft_pkg::out_word_t  result
);

	logic               push;
	logic               pop;
	pft_pkg::entry_t    push_entry;
	pft_pkg::entry_t    head;
	pft_pkg::q_status_t q_status;

	pft_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	pft_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	pft_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: src/pft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_checker: port-level checks of the PPP frame transmitter
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module pft_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_ready,
	input  pft_pkg::in_word_t   item,
	input  logic                result_valid,
	input  logic                result_ready,
	input  pft_pkg::out_word_t  result
);

	// a stalled input word holds
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("input word changed while stalled");

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_end_is_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_end |-> result.out_byte == pft_pkg::FLAG_BYTE)
		else $error("frame_end on a byte other than the flag");

	// an accepted word is followed by a valid result word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |-> ##2 result_valid)
		else $error("no output after an accepted word");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result valid during reset");

endmodule

bind ppp_frame_transmitter pft_checker u_pft_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

FILE: tb/sv/ppp_frame_transmitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_frame_transmitter_tb: self-checking bench for the PPP frame transmitter
// Feeds payload words through a randomly idling sender, predicts the framed
// byte stream (header, escapes, checksum, closing flag) and checks every
// output word in order against a randomly stalling receiver.
// ----------------------------------------------------------------------------
module ppp_frame_transmitter_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT    = 29;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_we       = 1'b0;
	logic [15:0]        cfg_wdata    = '0;
	logic               item_valid   = 1'b0;
	logic               item_ready;
	pft_pkg::in_word_t  item         = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	pft_pkg::out_word_t result;

	// framer model state
	logic [15:0] cfg_protocol = '0;
	logic        open_frame   = 1'b0;
	logic [15:0] run_sum      = '0;
	logic [7:0]  hi_byte      = '0;
	logic        hi_valid     = 1'b0;

	pft_pkg::in_word_t  pending_words[$];
	pft_pkg::out_word_t expected_bytes[$];
	pft_pkg::out_word_t next_expected;

	int          error_count  = 0;
	int          cycle_count  = 0;
	logic        calm_phase   = 1'b0;
	int          hold_token   = 0;
	int          hold_seen    = 0;
	int          hold_left    = 0;

	ppp_frame_transmitter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] ones_sum16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] wide;
		wide = {1'b0, a} + {1'b0, b};
		if (wide[16])
			wide = {1'b0, wide[15:0]} + 17'd1;
		return wide[15:0];
	endfunction

	task automatic expect_byte(input logic [7:0] b, input logic e);
		expected_bytes.push_back(pft_pkg::out_word_t'{out_byte: b, frame_end: e});
	endtask

	// predicts the output words caused by one accepted payload word
	task automatic frame_word(input pft_pkg::in_word_t w);
		logic [15:0] csum;
		if (!open_frame) begin
			expect_byte(pft_pkg::FLAG_BYTE, 1'b0);
			expect_byte(pft_pkg::ADDR_BYTE, 1'b0);
			expect_byte(pft_pkg::CTRL_BYTE, 1'b0);
			expect_byte(cfg_protocol[15:8], 1'b0);
			expect_byte(cfg_protocol[7:0], 1'b0);
			run_sum    = ones_sum16(pft_pkg::HDR_WORD, cfg_protocol);
			hi_valid   = 1'b0;
			open_frame = 1'b1;
		end
		if (w.data_byte == pft_pkg::ESC_BYTE || w.data_byte == pft_pkg::FLAG_BYTE) begin
			expect_byte(pft_pkg::ESC_BYTE, 1'b0);
			expect_byte(w.data_byte ^ pft_pkg::ESC_XOR, 1'b0);
		end else begin
			expect_byte(w.data_byte, 1'b0);
		end
		if (hi_valid) begin
			run_sum  = ones_sum16(run_sum, {hi_byte, w.data_byte});
			hi_valid = 1'b0;
		end else begin
			hi_byte  = w.data_byte;
			hi_valid = 1'b1;
		end
		if (w.last_byte) begin
			if (hi_valid)
				run_sum = ones_sum16(run_sum, {hi_byte, 8'h00});
			csum = ~run_sum;
			// checksum goes out raw, never escaped
			expect_byte(csum[15:8], 1'b0);
			expect_byte(csum[7:0], 1'b0);
			expect_byte(pft_pkg::FLAG_BYTE, 1'b1);
			open_frame = 1'b0;
			hi_valid   = 1'b0;
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else begin
			if (item_valid && item_ready)
				frame_word(item);
			if (!item_valid || item_ready) begin
				if (pending_words.size() != 0 &&
				    (calm_phase || $urandom_range(99) >= IDLE_PCT)) begin
					item       <= pending_words.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_bytes.size() == 0) begin
					if (error_count < 10)
						$display("unexpected word: byte %h end %b",
						         result.out_byte, result.frame_end);
					error_count++;
				end else begin
					next_expected = expected_bytes.pop_front();
					if (result.out_byte !== next_expected.out_byte ||
					    result.frame_end !== next_expected.frame_end) begin
						if (error_count < 10)
							$display("mismatch: expected byte %h end %b, got byte %h end %b",
							         next_expected.out_byte, next_expected.frame_end,
							         result.out_byte, result.frame_end);
						error_count++;
					end
				end
			end
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= calm_phase || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic put_word(input logic [7:0] b, input logic l);
		pending_words.push_back(pft_pkg::in_word_t'{data_byte: b, last_byte: l});
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || item_valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_protocol(input logic [15:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_protocol = v;
	endtask

	function automatic logic [7:0] rand_payload();
		int r;
		r = $urandom_range(99);
		if (r < 10)      return pft_pkg::FLAG_BYTE;
		else if (r < 20) return pft_pkg::ESC_BYTE;
		else if (r < 25) return 8'h00;
		else if (r < 30) return 8'hFF;
		else if (r < 35) return ($urandom_range(1) != 0) ? 8'h5D : 8'h5E;
		else             return 8'($urandom_range(255));
	endfunction

	// mostly short frames, a few long ones
	task automatic queue_random_frames(input int n_words, input bit leave_open);
		int len;
		int r;
		int k;
		k = 0;
		while (k < n_words) begin
			r = $urandom_range(99);
			if (r < 80)      len = $urandom_range(6, 1);
			else if (r < 95) len = $urandom_range(20, 7);
			else             len = $urandom_range(40, 21);
			for (int i = 0; i < len && k < n_words; i++) begin
				put_word(rand_payload(),
				         (i == len - 1) || (k == n_words - 1 && !leave_open));
				k++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// protocol at reset value; 82 7E makes a checksum of 7E 7D
		put_word(8'h82, 1'b0);
		put_word(8'h7E, 1'b1);
		put_word(8'h00, 1'b1);
		wait_drained();

		write_protocol(16'hFFFF);
		put_word(8'hFF, 1'b0);
		put_word(8'hFF, 1'b0);
		put_word(8'h7D, 1'b0);
		put_word(8'h7E, 1'b0);
		put_word(8'h5D, 1'b0);
		put_word(8'h5E, 1'b0);
		put_word(8'h7C, 1'b0);
		put_word(8'h7F, 1'b0);
		put_word(8'h01, 1'b0);
		put_word(8'h80, 1'b0);
		put_word(8'h20, 1'b1);
		// leave a frame open across the next protocol write
		put_word(8'h55, 1'b0);
		put_word(8'hAA, 1'b0);
		wait_drained();

		write_protocol(16'h7E7D);
		put_word(8'h33, 1'b1);
		// header bytes equal to flag/escape go out raw
		put_word(8'h7E, 1'b1);
		wait_drained();

		write_protocol(16'($urandom_range(65535)));
		queue_random_frames(36, 1'($urandom_range(1)));
		wait_drained();

		write_protocol(16'h0000);
		calm_phase <= 1'b1;
		queue_random_frames(36, 1'($urandom_range(1)));
		wait_drained();
		calm_phase <= 1'b0;

		write_protocol(16'hFFFF);
		hold_token <= hold_token + 1;
		queue_random_frames(36, 1'($urandom_range(1)));
		wait_drained();

		write_protocol({pft_pkg::ESC_BYTE, 8'($urandom_range(255))});
		queue_random_frames(36, 1'($urandom_range(1)));
		wait_drained();

		write_protocol(16'($urandom_range(65535)));
		queue_random_frames(36, 1'b0);
		wait_drained();

		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_bytes.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
